/* sv/tcw_pkg.sv */
// shared types and constants for the text console character writer
`default_nettype none

package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  // fixed field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 11;
  localparam int ATTR_W = 8;
  localparam int DATA_W = 16;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  // character codes with special meaning
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // sequencer to cursor unit
  typedef struct packed {
    logic put;
    logic home;
  } cur_ctl_t;

  // cursor unit back to sequencer
  typedef struct packed {
    logic printable;
    logic scroll;
  } cur_stat_t;

endpackage

`default_nettype wire

/* sv/tcw_screen_ram.sv */
// screen cell memory, one write port and one registered read port
`default_nettype none

module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int DW    = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/tcw_walker.sv */
// address counter with end compare, shared by every memory sweep
`default_nettype none

module tcw_walker #(
  parameter int CW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire logic [CW-1:0] load_val,
  input  wire logic          step,
  input  wire logic [CW-1:0] last_val,
  output logic      [CW-1:0] cnt,
  output logic               last
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= load_val;
    end else if (step) begin
      cnt <= cnt + CW'(1);
    end
  end

  assign last = (cnt == last_val);

endmodule

`default_nettype wire

/* sv/tcw_cursor.sv */
// cursor registers and the put-character cursor update
`default_nettype none

module tcw_cursor #(
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF,
  parameter int AW        = $clog2(ROWS * COLUMNS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tcw_pkg::cur_ctl_t           ctl,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code,
  output tcw_pkg::cur_stat_t               stat,
  output logic      [AW-1:0]               pos
);

  localparam int XW   = $clog2(COLUMNS);
  localparam int YW   = $clog2(ROWS);
  localparam int PW   = (TAB_WIDTH > 2) ? $clog2(TAB_WIDTH) : 1;
  localparam int XN_W = $clog2(COLUMNS + TAB_WIDTH);

  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [PW-1:0] phase;   // x modulo tab width, kept alongside x

  logic [XN_W-1:0] x_ext;
  logic [XN_W-1:0] x_new;
  logic [PW-1:0]   phase_new;
  logic            y_inc;
  logic            printable;
  logic            scroll;
  logic [YW-1:0]   y_new;

  assign printable = (char_code >= tcw_pkg::CH_PRINT_LO) &&
                     (char_code <= tcw_pkg::CH_PRINT_HI);

  always_comb begin
    x_ext     = XN_W'(x);
    x_new     = x_ext;
    phase_new = phase;
    y_inc     = 1'b0;
    priority if (char_code == tcw_pkg::CH_BS) begin
      if (x != '0) begin
        x_new     = x_ext - XN_W'(1);
        phase_new = (phase == '0) ? PW'(TAB_WIDTH - 1) : phase - PW'(1);
      end
    end else if (char_code == tcw_pkg::CH_TAB) begin
      x_new     = x_ext + XN_W'(TAB_WIDTH) - XN_W'(phase);
      phase_new = '0;
    end else if (char_code == tcw_pkg::CH_CR) begin
      x_new     = '0;
      phase_new = '0;
    end else if (char_code == tcw_pkg::CH_LF) begin
      x_new     = '0;
      phase_new = '0;
      y_inc     = 1'b1;
    end else if (printable) begin
      x_new     = x_ext + XN_W'(1);
      phase_new = (phase == PW'(TAB_WIDTH - 1)) ? '0 : phase + PW'(1);
    end else begin
      x_new = x_ext;
    end
    // line end wrap
    if (x_new >= XN_W'(COLUMNS)) begin
      x_new     = '0;
      phase_new = '0;
      y_inc     = 1'b1;
    end
  end

  assign scroll = y_inc && (y == YW'(ROWS - 1));
  assign y_new  = (y_inc && !scroll) ? y + YW'(1) : y;

  always_ff @(posedge clk) begin
    if (rst || ctl.home) begin
      x     <= '0;
      y     <= '0;
      phase <= '0;
    end else if (ctl.put) begin
      x     <= XW'(x_new);
      y     <= y_new;
      phase <= phase_new;
    end
  end

  assign stat.printable = printable;
  assign stat.scroll    = scroll;
  assign pos            = AW'(y) * AW'(COLUMNS) + AW'(x);

endmodule

`default_nettype wire

/* sv/text_console_char_writer.sv */
// text console character writer: sequencer, attribute register and result register
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   request  | in_valid / in_stall       | cmd, char_code, cell_index
//   result   | out_valid / out_stall     | cursor_pos, read_data, scrolled
//   config   | text_attribute_we         | text_attribute
//
// a put goes through S_PUT and S_DONE, a read or a no-op through S_DONE, a clear through
// S_CLEAR and S_DONE, and a put that scrolls adds S_COPY and S_BLANK; the sweeps
// move one cell a cycle through the single write port of the screen memory
// after reset a clearing pass over all ROWS*COLUMNS cells (2000 by default) fills
// the screen with blank cells, in_stall stays high meanwhile
// one request at a time; a new request is taken while the last result waits
// on out_stall, and the next result waits for the result register
`default_nettype none

module text_console_char_writer #(
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration
  input  wire logic                        text_attribute_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  text_attribute,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tcw_pkg::CMD_W-1:0]   cmd,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  wire logic [tcw_pkg::POS_W-1:0]   cell_index,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [tcw_pkg::POS_W-1:0]   cursor_pos,
  output logic      [tcw_pkg::DATA_W-1:0]  read_data,
  output logic                             scrolled
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int DW    = tcw_pkg::DATA_W;

  localparam logic [DW-1:0] BLANK_RESET = {tcw_pkg::ATTR_RESET, tcw_pkg::BLANK_CHAR};

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,  // clearing pass after reset
    S_IDLE  = 7'b0000010,
    S_PUT   = 7'b0000100,
    S_COPY  = 7'b0001000,  // scroll: move every line below the top up by one
    S_BLANK = 7'b0010000,  // scroll: blank the bottom line
    S_CLEAR = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [tcw_pkg::ATTR_W-1:0] attr;

  // captured request
  tcw_pkg::cmd_t              cmd_q;
  logic [tcw_pkg::CHAR_W-1:0] char_q;
  logic                       in_range_q;
  logic                       scroll_q;

  logic accept;
  logic out_free;

  // memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  // walker control
  logic          wk_load;
  logic [CW-1:0] wk_load_val;
  logic          wk_step;
  logic [CW-1:0] wk_last_val;
  logic [CW-1:0] wk_cnt;
  logic          wk_last;

  // cursor
  tcw_pkg::cur_ctl_t  cur_ctl;
  tcw_pkg::cur_stat_t cur_stat;
  logic [AW-1:0]      cur_pos;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // attribute register, written whenever the enable is up outside reset
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcw_pkg::ATTR_RESET;
    end else if (text_attribute_we) begin
      attr <= text_attribute;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= tcw_pkg::cmd_t'(cmd);
      char_q     <= char_code;
      in_range_q <= (32'(cell_index) < 32'(CELLS));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scroll_q <= 1'b0;
    end else if (state == S_PUT) begin
      scroll_q <= cur_stat.scroll;
    end
  end

  // sequencer
  always_comb begin
    state_next  = state;
    ram_we      = 1'b0;
    ram_waddr   = AW'(wk_cnt);
    ram_wdata   = {attr, tcw_pkg::BLANK_CHAR};
    ram_re      = 1'b0;
    ram_raddr   = AW'(wk_cnt);
    wk_load     = 1'b0;
    wk_load_val = '0;
    wk_step     = 1'b0;
    wk_last_val = CW'(CELLS - 1);
    cur_ctl     = '0;
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = BLANK_RESET;
        wk_step   = 1'b1;
        if (wk_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_re    = accept;
        ram_raddr = AW'(cell_index);
        if (accept) begin
          unique case (tcw_pkg::cmd_t'(cmd))
            tcw_pkg::CMD_PUT: begin
              state_next = S_PUT;
            end
            tcw_pkg::CMD_CLEAR: begin
              cur_ctl.home = 1'b1;
              wk_load      = 1'b1;
              wk_load_val  = '0;
              state_next   = S_CLEAR;
            end
            tcw_pkg::CMD_READ: begin
              state_next = S_DONE;
            end
            tcw_pkg::CMD_NONE: begin
              state_next = S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_PUT: begin
        // write a printable character at the old cursor, then move the cursor
        ram_we      = cur_stat.printable;
        ram_waddr   = cur_pos;
        ram_wdata   = {attr, char_q};
        cur_ctl.put = 1'b1;
        if (cur_stat.scroll) begin
          wk_load     = 1'b1;
          wk_load_val = CW'(COLUMNS);
          state_next  = S_COPY;
        end else begin
          state_next = S_DONE;
        end
      end
      S_COPY: begin
        // read cell n while cell n-1 lands one line higher
        wk_last_val = CW'(CELLS);
        ram_re      = !wk_last;
        ram_raddr   = AW'(wk_cnt);
        ram_we      = (wk_cnt != CW'(COLUMNS));
        ram_waddr   = AW'(wk_cnt - CW'(COLUMNS + 1));
        ram_wdata   = ram_rdata;
        if (wk_last) begin
          wk_load     = 1'b1;
          wk_load_val = CW'(CELLS - COLUMNS);
          state_next  = S_BLANK;
        end else begin
          wk_step = 1'b1;
        end
      end
      S_BLANK, S_CLEAR: begin
        ram_we  = 1'b1;
        wk_step = 1'b1;
        if (wk_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      cursor_pos <= tcw_pkg::POS_W'(cur_pos);
      read_data  <= (cmd_q == tcw_pkg::CMD_READ && in_range_q) ? ram_rdata : '0;
      scrolled   <= scroll_q;
    end
  end

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_walker #(
    .CW (CW)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .load     (wk_load),
    .load_val (wk_load_val),
    .step     (wk_step),
    .last_val (wk_last_val),
    .cnt      (wk_cnt),
    .last     (wk_last)
  );

  tcw_cursor #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH),
    .AW        (AW)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .ctl       (cur_ctl),
    .char_code (char_q),
    .stat      (cur_stat),
    .pos       (cur_pos)
  );

endmodule

`default_nettype wire

/* sv/tcw_checker.sv */
// port-level checks for the text console character writer, bound to the top level
`default_nettype none

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [tcw_pkg::POS_W-1:0]   cursor_pos,
  input wire logic [tcw_pkg::DATA_W-1:0]  read_data,
  input wire logic                        scrolled
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam logic [tcw_pkg::POS_W-1:0] LAST_ROW_POS =
    tcw_pkg::POS_W'((ROWS - 1) * COLUMNS);

  // cursor never leaves the screen
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(cursor_pos) < 32'(CELLS)))
    else $error("cursor_pos beyond the screen");

  // a scroll leaves the cursor at the start of the bottom line
  a_scroll_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> (cursor_pos == LAST_ROW_POS))
    else $error("scroll left cursor off the bottom line start");

  // only a put scrolls, and a put returns no cell data
  a_scroll_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> (read_data == '0))
    else $error("scrolled result carries read data");

  // every request that is taken makes the block busy and raises in_stall
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken on back to back cycles");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(cursor_pos) &&
                                  $stable(read_data) && $stable(scrolled)))
    else $error("stalled result changed");

endmodule

bind text_console_char_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .cursor_pos (cursor_pos),
  .read_data  (read_data),
  .scrolled   (scrolled)
);

`default_nettype wire
